@@ hdl/tapered_capsule_signed_distance_unit_macros.svh @@
// Assertion macros for the tapered capsule distance unit.
// No dependencies; included by the files that carry assertions.
`ifndef TAPERED_CAPSULE_SIGNED_DISTANCE_UNIT_MACROS_SVH
`define TAPERED_CAPSULE_SIGNED_DISTANCE_UNIT_MACROS_SVH

// Condition must never hold at a clock edge outside reset
`define TCSD_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

// When pre holds, post must hold in the following cycle
`define TCSD_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("expected follow-up missing");

`endif

@@ hdl/tcsd_pkg.sv @@
// Shared widths, constants and types of the tapered capsule distance unit.
// No dependencies.
package tcsd_pkg;

   localparam int WORD_BITS  = 32;
   localparam int FRAC_BITS  = 16;
   localparam int RAD_BITS   = WORD_BITS - 1;
   localparam int DIFF_BITS  = WORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int DOT_BITS   = PROD_BITS + 2;
   localparam int H_BITS     = FRAC_BITS + 1;
   localparam int Q_BITS     = DIFF_BITS + 1;
   localparam int SUMSQ_BITS = 2 * Q_BITS;
   localparam int LEN_BITS   = Q_BITS;
   localparam int BH_BITS    = DIFF_BITS + H_BITS;
   localparam int LERP_BITS  = RAD_BITS + H_BITS;

   localparam int CSR_COUNT      = 8;
   localparam int CSR_INDEX_BITS = $clog2(CSR_COUNT);

   localparam int MID_DEPTH    = 4;
   localparam int MID_PTR_BITS = $clog2(MID_DEPTH);
   localparam int OUT_DEPTH    = 2;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);

   localparam longint unsigned ONE_L     = 64'd1 << FRAC_BITS;
   localparam longint unsigned RAD_MIN_L = (ONE_L + 64'd9999) / 64'd10000;
   localparam longint unsigned DEGEN_L   = (64'd1 << (2 * FRAC_BITS)) / 64'd100000000;

   localparam logic [H_BITS-1:0]    H_ONE_VAL    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [RAD_BITS-1:0]  RAD_MIN      = RAD_BITS'(RAD_MIN_L);
   localparam logic [RAD_BITS-1:0]  RADIUS_RESET = RAD_BITS'(ONE_L);
   localparam logic [DOT_BITS-1:0]  DEGEN_LIMIT  = DOT_BITS'(DEGEN_L);
   localparam logic [BH_BITS:0]     ROUND_HALF   = (BH_BITS + 1)'(ONE_L >> 1);

   typedef logic signed [WORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0] diff_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_START_X, CSR_START_Y, CSR_START_Z,
      CSR_END_X, CSR_END_Y, CSR_END_Z,
      CSR_START_RADIUS, CSR_END_RADIUS
   } csr_index_type;

   // How the projection parameter is settled
   typedef enum logic [1:0] {
      HMODE_ZERO, HMODE_ONE, HMODE_DIV
   } hmode_type;

   // CSR-derived segment data, kept stable while items run by user alone
   typedef struct packed {
      logic [2:0][DIFF_BITS-1:0] ba_mag;
      logic [2:0]                ba_neg;
      logic [DOT_BITS-1:0]       len2;
      logic [RAD_BITS-1:0]       r_start;
      logic [RAD_BITS-1:0]       r_end;
   } geom_type;

   // Classified word handed from front to back
   typedef struct packed {
      diff_type            pa_x;
      diff_type            pa_y;
      diff_type            pa_z;
      logic [DOT_BITS-1:0] rem;
      hmode_type           mode;
   } mid_type;

endpackage

@@ hdl/tcsd_front.sv @@
// Front end: registers, segment set-up and classification of each point.
// Depends on tcsd_pkg.
module tcsd_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [tcsd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tcsd_pkg::WORD_BITS-1:0]       csr_wdata,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [tcsd_pkg::WORD_BITS-1:0] req_point_x,
   input  logic signed [tcsd_pkg::WORD_BITS-1:0] req_point_y,
   input  logic signed [tcsd_pkg::WORD_BITS-1:0] req_point_z,
   output tcsd_pkg::geom_type                   geom,
   output logic                                 mid_push,
   output tcsd_pkg::mid_type                    mid_item,
   input  logic                                 mid_full
);
   import tcsd_pkg::*;

   coord_type                    start_ff [3];
   coord_type                    end_ff [3];
   logic [RAD_BITS-1:0]          r_start_ff, r_end_ff;
   diff_type                     ba_ff [3];
   logic [DIFF_BITS-1:0]         bam_ff [3];
   logic [2:0]                   ban_ff;
   logic signed [PROD_BITS-1:0]  bsq_ff [3];
   logic [DOT_BITS-1:0]          len2_ff;
   logic [RAD_BITS-1:0]          rs_ff, re_ff;

   coord_type                    point [3];
   logic [3:0]                   s_valid_ff;
   diff_type                     pa1_ff [3], pa2_ff [3], pa3_ff [3];
   logic signed [PROD_BITS-1:0]  prod2_ff [3];
   logic signed [DOT_BITS-1:0]   dt3_ff, dt_in, len2_in;
   mid_type                      mid_ff, mid_in;
   logic                         adv, degen, dt_pos;

   assign point[0] = req_point_x;
   assign point[1] = req_point_y;
   assign point[2] = req_point_z;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            start_ff[i] <= '0;
            end_ff[i]   <= '0;
         end
         r_start_ff <= RADIUS_RESET;
         r_end_ff   <= RADIUS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_X:      start_ff[0] <= csr_wdata;
            CSR_START_Y:      start_ff[1] <= csr_wdata;
            CSR_START_Z:      start_ff[2] <= csr_wdata;
            CSR_END_X:        end_ff[0]   <= csr_wdata;
            CSR_END_Y:        end_ff[1]   <= csr_wdata;
            CSR_END_Z:        end_ff[2]   <= csr_wdata;
            CSR_START_RADIUS: r_start_ff  <= csr_wdata[RAD_BITS-1:0];
            CSR_END_RADIUS:   r_end_ff    <= csr_wdata[RAD_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign len2_in = $signed({{2{bsq_ff[0][PROD_BITS-1]}}, bsq_ff[0]})
                  + $signed({{2{bsq_ff[1][PROD_BITS-1]}}, bsq_ff[1]})
                  + $signed({{2{bsq_ff[2][PROD_BITS-1]}}, bsq_ff[2]});

   // Segment axis, its squared length and the clamped radii
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ba_ff[i]  <= '0;
            bam_ff[i] <= '0;
            bsq_ff[i] <= '0;
         end
         ban_ff  <= '0;
         len2_ff <= '0;
         rs_ff   <= RADIUS_RESET;
         re_ff   <= RADIUS_RESET;
      end else begin
         for (int i = 0; i < 3; i++) begin
            ba_ff[i]  <= $signed({end_ff[i][WORD_BITS-1], end_ff[i]})
                       - $signed({start_ff[i][WORD_BITS-1], start_ff[i]});
            bam_ff[i] <= ba_ff[i][DIFF_BITS-1] ? $unsigned(-ba_ff[i]) : $unsigned(ba_ff[i]);
            ban_ff[i] <= ba_ff[i][DIFF_BITS-1];
            bsq_ff[i] <= ba_ff[i] * ba_ff[i];
         end
         len2_ff <= $unsigned(len2_in);
         rs_ff   <= (r_start_ff < RAD_MIN) ? RAD_MIN : r_start_ff;
         re_ff   <= (r_end_ff < RAD_MIN) ? RAD_MIN : r_end_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         geom.ba_mag[i] = bam_ff[i];
      end
      geom.ba_neg  = ban_ff;
      geom.len2    = len2_ff;
      geom.r_start = rs_ff;
      geom.r_end   = re_ff;
   end

   // Hold the point stages of the front while the last stage cannot hand over
   assign adv      = !(s_valid_ff[3] && mid_full);
   assign req_full = !adv;
   assign mid_push = s_valid_ff[3] && !mid_full;
   assign mid_item = mid_ff;

   assign dt_in = $signed({{2{prod2_ff[0][PROD_BITS-1]}}, prod2_ff[0]})
                + $signed({{2{prod2_ff[1][PROD_BITS-1]}}, prod2_ff[1]})
                + $signed({{2{prod2_ff[2][PROD_BITS-1]}}, prod2_ff[2]});

   // Classify: degenerate segment or clamped parameter do not use the divider quotient
   always_comb begin
      degen  = len2_ff < DEGEN_LIMIT;
      dt_pos = !dt3_ff[DOT_BITS-1] && (dt3_ff != '0);
      mid_in.pa_x = pa3_ff[0];
      mid_in.pa_y = pa3_ff[1];
      mid_in.pa_z = pa3_ff[2];
      mid_in.rem  = '0;
      if (degen || !dt_pos) begin
         mid_in.mode = HMODE_ZERO;
      end else if ($unsigned(dt3_ff) >= len2_ff) begin
         mid_in.mode = HMODE_ONE;
      end else begin
         mid_in.mode = HMODE_DIV;
         mid_in.rem  = $unsigned(dt3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= '0;
      end else if (adv) begin
         s_valid_ff <= {s_valid_ff[2:0], req_push};
      end
   end

   // Offset, dot product terms, dot sum, classification
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            pa1_ff[i]   <= $signed({point[i][WORD_BITS-1], point[i]})
                         - $signed({start_ff[i][WORD_BITS-1], start_ff[i]});
            pa2_ff[i]   <= pa1_ff[i];
            prod2_ff[i] <= pa1_ff[i] * ba_ff[i];
            pa3_ff[i]   <= pa2_ff[i];
         end
         dt3_ff <= dt_in;
         mid_ff <= mid_in;
      end
   end

endmodule

@@ hdl/tcsd_queue.sv @@
// Short queue between the front and back ends of the distance unit.
// Depends on tcsd_pkg and the assertion macro header.
`include "tapered_capsule_signed_distance_unit_macros.svh"
module tcsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcsd_pkg::mid_type wdata,
   output logic              full,
   input  logic              pop,
   output tcsd_pkg::mid_type rdata,
   output logic              empty
);
   import tcsd_pkg::*;

   mid_type                 mem_ff [MID_DEPTH];
   logic [MID_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [MID_PTR_BITS:0]   count_ff;

   assign full  = count_ff == (MID_PTR_BITS + 1)'(MID_DEPTH);
   assign empty = count_ff == '0;
   assign rdata = mem_ff[rd_ptr_ff];

   // Store incoming words
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   `TCSD_ASSERT_NEVER(a_count_range, clock, reset, count_ff > (MID_PTR_BITS + 1)'(MID_DEPTH))
   `TCSD_ASSERT_NEVER(a_no_overflow, clock, reset, push && full)
   `TCSD_ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty)
   `TCSD_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

@@ hdl/tcsd_back.sv @@
// Back end: divider, lerp and projection, squared length, square root,
// saturation and the result queue. Depends on tcsd_pkg.
module tcsd_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tcsd_pkg::geom_type                    geom,
   input  logic                                  mid_empty,
   input  tcsd_pkg::mid_type                     mid_item,
   output logic                                  mid_pop,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [tcsd_pkg::WORD_BITS-1:0] rsp_distance
);
   import tcsd_pkg::*;

   localparam logic signed [LEN_BITS+1:0] D_MAX =
      (LEN_BITS + 2)'((64'd1 << (WORD_BITS - 1)) - 64'd1);
   localparam logic signed [LEN_BITS+1:0] D_MIN = -D_MAX - 1;

   logic adv;

   // Divider stages
   logic [FRAC_BITS:0]   dv_valid_ff;
   mid_type              dv_item_ff [FRAC_BITS+1];
   logic [FRAC_BITS-1:0] dv_quo_ff [FRAC_BITS+1];

   // Projection and lerp stages
   logic [2:0]                 pv_ff;
   logic [H_BITS-1:0]          h_in;
   diff_type                   pa_in [3];
   diff_type                   pa1_ff [3];
   logic [BH_BITS-1:0]         bh1_ff [3];
   logic [LERP_BITS-1:0]       la1_ff, lb1_ff;
   logic signed [Q_BITS-1:0]   q2_ff [3];
   logic [RAD_BITS-1:0]        r2_ff, r3_ff;
   logic [SUMSQ_BITS-1:0]      sq3_ff [3];

   // Square root stages
   logic [LEN_BITS:0]          sr_valid_ff;
   logic [SUMSQ_BITS-1:0]      sr_rem_ff [LEN_BITS+1];
   logic [LEN_BITS-1:0]        sr_root_ff [LEN_BITS+1];
   logic [RAD_BITS-1:0]        sr_r_ff [LEN_BITS+1];

   // Output stage and result queue
   logic                       f_valid_ff;
   coord_type                  f_dist_ff, dist_in;
   logic signed [LEN_BITS+1:0] d_in;
   coord_type                  oq_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0]    oq_wr_ff, oq_rd_ff;
   logic [OUT_PTR_BITS:0]      oq_count_ff;
   logic                       oq_full, oq_push, oq_pop;

   // Stall the whole back end only when the finished word cannot leave
   assign oq_full = oq_count_ff == (OUT_PTR_BITS + 1)'(OUT_DEPTH);
   assign adv     = !(f_valid_ff && oq_full);
   assign mid_pop = adv && !mid_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
         pv_ff       <= '0;
         sr_valid_ff <= '0;
         f_valid_ff  <= 1'b0;
      end else if (adv) begin
         dv_valid_ff <= {dv_valid_ff[FRAC_BITS-1:0], !mid_empty};
         pv_ff       <= {pv_ff[1:0], dv_valid_ff[FRAC_BITS]};
         sr_valid_ff <= {sr_valid_ff[LEN_BITS-1:0], pv_ff[2]};
         f_valid_ff  <= sr_valid_ff[LEN_BITS];
      end
   end

   // Load from the queue
   always_ff @(posedge clock) begin
      if (adv) begin
         dv_item_ff[0] <= mid_item;
         dv_quo_ff[0]  <= '0;
      end
   end

   // One quotient bit a stage, restoring
   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_div
      logic [DOT_BITS-1:0] rem2;
      logic                take;
      mid_type             nxt_item;
      assign rem2 = {dv_item_ff[k].rem[DOT_BITS-2:0], 1'b0};
      assign take = rem2 >= geom.len2;
      always_comb begin
         nxt_item     = dv_item_ff[k];
         nxt_item.rem = take ? rem2 - geom.len2 : rem2;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_item_ff[k+1] <= nxt_item;
            dv_quo_ff[k+1]  <= {dv_quo_ff[k][FRAC_BITS-2:0], take};
         end
      end
   end

   // Pick the projection parameter
   always_comb begin
      case (dv_item_ff[FRAC_BITS].mode)
         HMODE_ONE: h_in = H_ONE_VAL;
         HMODE_DIV: h_in = {1'b0, dv_quo_ff[FRAC_BITS]};
         default:   h_in = '0;
      endcase
      pa_in[0] = dv_item_ff[FRAC_BITS].pa_x;
      pa_in[1] = dv_item_ff[FRAC_BITS].pa_y;
      pa_in[2] = dv_item_ff[FRAC_BITS].pa_z;
   end

   // Products for the projection and the lerp
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            bh1_ff[i] <= geom.ba_mag[i] * h_in;
            pa1_ff[i] <= pa_in[i];
         end
         la1_ff <= geom.r_start * (H_ONE_VAL - h_in);
         lb1_ff <= geom.r_end * h_in;
      end
   end

   // Round, remove the projection from the offset, finish the lerp
   always_ff @(posedge clock) begin
      logic [BH_BITS:0]           rnd;
      logic signed [Q_BITS-1:0]   mq, pq;
      logic [LERP_BITS:0]         lsum;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            rnd = {1'b0, bh1_ff[i]} + ROUND_HALF;
            mq  = $signed({1'b0, rnd[FRAC_BITS +: DIFF_BITS]});
            pq  = $signed({pa1_ff[i][DIFF_BITS-1], pa1_ff[i]});
            q2_ff[i] <= geom.ba_neg[i] ? pq + mq : pq - mq;
         end
         lsum  = {1'b0, la1_ff} + {1'b0, lb1_ff};
         r2_ff <= lsum[FRAC_BITS +: RAD_BITS];
      end
   end

   // Squares of the remaining offset
   always_ff @(posedge clock) begin
      logic signed [SUMSQ_BITS-1:0] sq;
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq = q2_ff[i] * q2_ff[i];
            sq3_ff[i] <= $unsigned(sq);
         end
         r3_ff <= r2_ff;
      end
   end

   // Sum of squares opens the root pipeline
   always_ff @(posedge clock) begin
      if (adv) begin
         sr_rem_ff[0]  <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
         sr_root_ff[0] <= '0;
         sr_r_ff[0]    <= r3_ff;
      end
   end

   // One root bit a stage, most significant first
   for (genvar g = 0; g < LEN_BITS; g++) begin : g_sqrt
      localparam int B = LEN_BITS - 1 - g;
      logic [SUMSQ_BITS:0] trial;
      logic                take;
      assign trial = ((SUMSQ_BITS + 1)'(sr_root_ff[g]) << (B + 1))
                   | ((SUMSQ_BITS + 1)'(1) << (2 * B));
      assign take  = {1'b0, sr_rem_ff[g]} >= trial;
      always_ff @(posedge clock) begin
         if (adv) begin
            sr_rem_ff[g+1]  <= take ? sr_rem_ff[g] - trial[SUMSQ_BITS-1:0] : sr_rem_ff[g];
            sr_root_ff[g+1] <= take ? sr_root_ff[g] | (LEN_BITS'(1) << B) : sr_root_ff[g];
            sr_r_ff[g+1]    <= sr_r_ff[g];
         end
      end
   end

   // Length minus radius, saturated
   always_comb begin
      d_in = $signed({2'b00, sr_root_ff[LEN_BITS]})
           - $signed((LEN_BITS + 2)'(sr_r_ff[LEN_BITS]));
      if (d_in > D_MAX) begin
         dist_in = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (d_in < D_MIN) begin
         dist_in = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         dist_in = d_in[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_dist_ff <= dist_in;
      end
   end

   // Result queue
   assign oq_push      = adv && f_valid_ff;
   assign rsp_empty    = oq_count_ff == '0;
   assign oq_pop       = rsp_pop && !rsp_empty;
   assign rsp_distance = oq_mem_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_mem_ff[oq_wr_ff] <= f_dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         if (oq_push) oq_wr_ff <= oq_wr_ff + 1'b1;
         if (oq_pop)  oq_rd_ff <= oq_rd_ff + 1'b1;
         case ({oq_push, oq_pop})
            2'b10:   oq_count_ff <= oq_count_ff + 1'b1;
            2'b01:   oq_count_ff <= oq_count_ff - 1'b1;
            default: oq_count_ff <= oq_count_ff;
         endcase
      end
   end

endmodule

@@ hdl/tapered_capsule_signed_distance_unit.sv @@
// Top level of the tapered capsule signed distance unit.
// Depends on tcsd_pkg, tcsd_front, tcsd_queue and tcsd_back.
//
//   channel   direction  handshake            payload
//   req       in         req_push / req_full  req_point_x, req_point_y, req_point_z
//   rsp       out        rsp_pop / rsp_empty  rsp_distance
//   csr       in         csr_write_en         csr_index, csr_wdata
//
// One point is taken each cycle while req_full is low; each result passes
// through the 16-stage divider and the 34-stage square root pipeline.
// Synchronous active-high reset clears the queues and valid bits and
// returns the registers to their reset values.
// A full result queue holds the back end; the four-word middle queue then
// fills and holds the front, which raises req_full.
module tapered_capsule_signed_distance_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [tcsd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tcsd_pkg::WORD_BITS-1:0]        csr_wdata,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [tcsd_pkg::WORD_BITS-1:0] req_point_x,
   input  logic signed [tcsd_pkg::WORD_BITS-1:0] req_point_y,
   input  logic signed [tcsd_pkg::WORD_BITS-1:0] req_point_z,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic signed [tcsd_pkg::WORD_BITS-1:0] rsp_distance
);
   import tcsd_pkg::*;

   geom_type geom;
   mid_type  mid_wdata, mid_rdata;
   logic     mid_push, mid_full, mid_pop, mid_empty;

   // Accept and classify
   tcsd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_point_z  (req_point_z),
      .geom         (geom),
      .mid_push     (mid_push),
      .mid_item     (mid_wdata),
      .mid_full     (mid_full)
   );

   // Decouple the two halves
   tcsd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   // Compute and deliver
   tcsd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .geom         (geom),
      .mid_empty    (mid_empty),
      .mid_item     (mid_rdata),
      .mid_pop      (mid_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_distance (rsp_distance)
   );

endmodule
